// ===== rtl/core/tpi_pkg.sv =====
// Shared types and constants of the trail point interpolator.
package tpi_pkg;

   localparam int RING_SLOTS  = 64;
   localparam int SLOT_CNT_W  = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
   localparam int SLOT_W      = 6;
   localparam int COORD_W     = 32;
   localparam int NUM_W       = COORD_W + 4;
   localparam int NCOORD      = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Coordinate order inside a vector: start x, y, z, then end x, y, z.
   typedef logic [NCOORD-1:0][COORD_W-1:0] vec_type;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_FIRST,
      KIND_FOLLOW
   } kind_type;

   typedef struct packed {
      logic               mode;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic               active;
      logic signed [31:0] out_start_x;
      logic signed [31:0] out_start_y;
      logic signed [31:0] out_start_z;
      logic signed [31:0] out_end_x;
      logic signed [31:0] out_end_y;
      logic signed [31:0] out_end_z;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      kind_type kind;
      vec_type  prior;
      vec_type  delta_old;
      vec_type  delta_new;
      vec_type  point;
   } entry_type;

endpackage

// ===== rtl/core/tpi_front.sv =====
// Front end: classify each item, keep prior point and motion deltas.
module tpi_front import tpi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   output logic      push_valid,
   output entry_type push_entry,
   input  logic      push_ready
);

   logic    prev_add_ff, prev_add_in;
   vec_type prior_ff, prior_in;
   vec_type delta_ff, delta_in;
   vec_type new_vec;
   logic    accept;

   assign new_vec = {req_data.end_z, req_data.end_y, req_data.end_x,
                     req_data.start_z, req_data.start_y, req_data.start_x};

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   always_comb begin
      push_entry.prior     = prior_ff;
      push_entry.delta_old = delta_ff;
      push_entry.point     = new_vec;
      for (int i = 0; i < NCOORD; i++) begin
         push_entry.delta_new[i] = new_vec[i] - prior_ff[i];
      end
      if (!req_data.mode) begin
         push_entry.kind = KIND_TICK;
      end else if (!prev_add_ff) begin
         push_entry.kind = KIND_FIRST;
      end else begin
         push_entry.kind = KIND_FOLLOW;
      end

      prev_add_in = prev_add_ff;
      prior_in    = prior_ff;
      delta_in    = delta_ff;
      if (accept) begin
         prev_add_in = req_data.mode;
         if (req_data.mode) begin
            prior_in = new_vec;
            // A first add starts from rest; a following add records its motion.
            delta_in = prev_add_ff ? push_entry.delta_new : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_add_ff <= 1'b0;
         prior_ff    <= '0;
         delta_ff    <= '0;
      end else begin
         prev_add_ff <= prev_add_in;
         prior_ff    <= prior_in;
         delta_ff    <= delta_in;
      end
   end

endmodule

// ===== rtl/core/tpi_queue.sv =====
// Short register queue between the front and back ends.
module tpi_queue import tpi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_entry
);

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push, pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/tpi_back.sv =====
// Back end: expand each queued item into four slot writes through a short pipeline.
module tpi_back import tpi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  entry_type pop_entry,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   typedef logic [1:0] beat_type;
   typedef logic [NCOORD-1:0][NUM_W-1:0] num_vec_type;

   localparam beat_type BEAT_EARLY  = 2'd0;
   localparam beat_type BEAT_MIDDLE = 2'd1;
   localparam beat_type BEAT_LATE   = 2'd2;
   localparam beat_type BEAT_LAST   = 2'd3;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              active;
      logic              last;
      logic              div4;
      vec_type           base;
      num_vec_type       num;
   } n_stage_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              active;
      logic              last;
      vec_type           base;
      vec_type           quo;
   } q_stage_type;

   beat_type              beat_ff, beat_in;
   logic [SLOT_CNT_W-1:0] slot_ff, slot_in;
   logic                  n_valid_ff, n_valid_in;
   logic                  q_valid_ff, q_valid_in;
   logic                  o_valid_ff, o_valid_in;
   n_stage_type           n_ff, n_in;
   q_stage_type           q_ff, q_in;
   rsp_type               o_ff, o_in;
   logic                  o_ready, q_ready, n_ready, issue;
   vec_type               out_vec;

   assign o_ready   = !o_valid_ff || rsp_ready;
   assign q_ready   = !q_valid_ff || o_ready;
   assign n_ready   = !n_valid_ff || q_ready;
   assign issue     = pop_valid && n_ready;
   assign pop_ready = n_ready && (beat_ff == BEAT_LAST);

   // Beat generation and numerators.
   always_comb begin
      logic                    interp;
      logic                    point_beat;
      logic signed [NUM_W-1:0] p, v, p3, v9;
      interp     = (pop_entry.kind == KIND_FOLLOW) && (beat_ff != BEAT_LAST);
      point_beat = (pop_entry.kind != KIND_TICK) && (beat_ff == BEAT_LAST);
      n_in.slot   = SLOT_W'(slot_ff);
      n_in.active = interp || point_beat;
      n_in.last   = beat_ff == BEAT_LAST;
      n_in.div4   = beat_ff == BEAT_MIDDLE;
      for (int i = 0; i < NCOORD; i++) begin
         p  = NUM_W'($signed(pop_entry.delta_old[i]));
         v  = NUM_W'($signed(pop_entry.delta_new[i]));
         p3 = p + (p <<< 1);
         v9 = v + (v <<< 3);
         case (beat_ff)
            BEAT_EARLY:  n_in.num[i] = p3 + v;
            BEAT_MIDDLE: n_in.num[i] = p + v;
            BEAT_LATE:   n_in.num[i] = p3 + v9;
            default:     n_in.num[i] = '0;
         endcase
         if (!interp) begin
            n_in.num[i] = '0;
         end
         if (interp) begin
            n_in.base[i] = pop_entry.prior[i];
         end else if (point_beat) begin
            n_in.base[i] = pop_entry.point[i];
         end else begin
            n_in.base[i] = '0;
         end
      end

      beat_in = beat_ff;
      slot_in = slot_ff;
      if (issue) begin
         beat_in = (beat_ff == BEAT_LAST) ? BEAT_EARLY : beat_ff + 1'b1;
         slot_in = (slot_ff == SLOT_CNT_W'(RING_SLOTS - 1)) ? '0 : slot_ff + 1'b1;
      end
   end

   // Truncating division by 16 or 4: bias negatives, then shift.
   always_comb begin
      logic signed [NUM_W-1:0] biased;
      logic signed [NUM_W-1:0] shifted;
      q_in.slot   = n_ff.slot;
      q_in.active = n_ff.active;
      q_in.last   = n_ff.last;
      q_in.base   = n_ff.base;
      for (int i = 0; i < NCOORD; i++) begin
         biased = $signed(n_ff.num[i]);
         if (n_ff.num[i][NUM_W-1]) begin
            biased = biased + (n_ff.div4 ? NUM_W'(3) : NUM_W'(15));
         end
         shifted     = n_ff.div4 ? (biased >>> 2) : (biased >>> 4);
         q_in.quo[i] = shifted[COORD_W-1:0];
      end
   end

   // Final sum wraps to 32 bits.
   always_comb begin
      for (int i = 0; i < NCOORD; i++) begin
         out_vec[i] = q_ff.base[i] + q_ff.quo[i];
      end
      o_in.slot        = q_ff.slot;
      o_in.active      = q_ff.active;
      o_in.last_of_run = q_ff.last;
      o_in.out_start_x = out_vec[0];
      o_in.out_start_y = out_vec[1];
      o_in.out_start_z = out_vec[2];
      o_in.out_end_x   = out_vec[3];
      o_in.out_end_y   = out_vec[4];
      o_in.out_end_z   = out_vec[5];
   end

   always_comb begin
      n_valid_in = n_ready ? issue : n_valid_ff;
      q_valid_in = q_ready ? n_valid_ff : q_valid_ff;
      o_valid_in = o_ready ? q_valid_ff : o_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff    <= BEAT_EARLY;
         slot_ff    <= '0;
         n_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         beat_ff    <= beat_in;
         slot_ff    <= slot_in;
         n_valid_ff <= n_valid_in;
         q_valid_ff <= q_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         n_ff <= n_in;
      end
      if (q_ready && n_valid_ff) begin
         q_ff <= q_in;
      end
      if (o_ready && q_valid_ff) begin
         o_ff <= o_in;
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_data  = o_ff;

   a_beat_wraps: assert property (@(posedge clock) disable iff (reset)
      issue && (beat_ff == BEAT_LAST) |=> beat_ff == BEAT_EARLY)
      else $error("beat counter did not wrap after the last beat");

   a_slot_advance: assert property (@(posedge clock) disable iff (reset)
      issue |=> slot_ff == (($past(slot_ff) == SLOT_CNT_W'(RING_SLOTS - 1)) ?
                            '0 : $past(slot_ff) + 1'b1))
      else $error("slot pointer did not advance by one per write");

   a_inactive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.active |->
         rsp_data.out_start_x == '0 && rsp_data.out_start_y == '0 &&
         rsp_data.out_start_z == '0 && rsp_data.out_end_x == '0 &&
         rsp_data.out_end_y == '0 && rsp_data.out_end_z == '0)
      else $error("inactive slot carries nonzero coordinates");

endmodule

// ===== rtl/core/trail_point_interpolator.sv =====
// Top level of the trail point interpolator.
// Each accepted item (a tick, or a new start/end point pair in signed 16.16)
// produces exactly four slot writes for a downstream ring of RING_SLOTS trail
// points, one result item per cycle while rsp_ready holds; last_of_run marks
// the fourth. A tick clears four slots. An add after a tick (or the first add)
// clears three slots and then writes the point. An add after an add writes
// three points interpolated from the previous and new motion, then the point
// itself. The back end issues one slot write per cycle unless the result
// channel stalls it. The front end classifies items and keeps the prior point
// and deltas; a two-entry queue lets it take the next item while the back end
// is still writing slots. An accepted item passes through the queue register
// and then the numerator, division and sum stages. The ring store itself lives
// downstream.
module trail_point_interpolator import tpi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   // Classify the item and update prior point and deltas on acceptance.
   tpi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   // Hold classified items until the back end drains them.
   tpi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Expand each item into four slot writes.
   tpi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
